[rtl/core/instruction_cycle_timing_defines.svh]
// Assertion macros for the instruction cycle timing block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef INSTRUCTION_CYCLE_TIMING_DEFINES_SVH
`define INSTRUCTION_CYCLE_TIMING_DEFINES_SVH

// Same-cycle implication.
`define ICT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked a fixed number of cycles later.
`define ICT_ASSERT_DLY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

[rtl/core/ict_pkg.sv]
// Shared types, move tables and address-mode cost functions for the
// instruction cycle timing block. No dependencies.
`default_nettype none

package ict_pkg;

  typedef enum logic [2:0] {
    OP_EA_COST   = 3'd0,
    OP_MOVE      = 3'd1,
    OP_ADD_SUB   = 3'd2,
    OP_CMP       = 3'd3,
    OP_ADDX_SUBX = 3'd4
  } op_e;

  localparam int unsigned NUM_CLASSES = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [2:0] op;
    logic [3:0] src_cls;
    logic [3:0] dst_cls;
    logic       lng;
    logic       byte_sz;
    logic       to_ea;
    logic       wide_base;  // long with register or immediate source
    logic       mem;
    logic [4:0] ea_cost;
  } req_t;

  // Indexed [destination class][source class].
  localparam logic [5:0] MOVE_BW_TAB [NUM_CLASSES][NUM_CLASSES] = '{
    '{6'd4,  6'd4,  6'd8,  6'd8,  6'd8,  6'd12, 6'd14, 6'd12, 6'd16, 6'd12, 6'd14, 6'd8},
    '{6'd4,  6'd4,  6'd8,  6'd8,  6'd8,  6'd12, 6'd14, 6'd12, 6'd16, 6'd12, 6'd14, 6'd8},
    '{6'd8,  6'd8,  6'd12, 6'd12, 6'd12, 6'd16, 6'd18, 6'd16, 6'd20, 6'd16, 6'd18, 6'd12},
    '{6'd8,  6'd8,  6'd12, 6'd12, 6'd12, 6'd16, 6'd18, 6'd16, 6'd20, 6'd16, 6'd18, 6'd12},
    '{6'd10, 6'd10, 6'd14, 6'd14, 6'd14, 6'd18, 6'd20, 6'd18, 6'd22, 6'd18, 6'd20, 6'd14},
    '{6'd12, 6'd12, 6'd16, 6'd16, 6'd16, 6'd20, 6'd22, 6'd20, 6'd24, 6'd20, 6'd22, 6'd16},
    '{6'd14, 6'd14, 6'd18, 6'd18, 6'd18, 6'd22, 6'd24, 6'd22, 6'd26, 6'd22, 6'd24, 6'd18},
    '{6'd12, 6'd12, 6'd16, 6'd16, 6'd16, 6'd20, 6'd22, 6'd20, 6'd24, 6'd20, 6'd22, 6'd16},
    '{6'd16, 6'd16, 6'd20, 6'd20, 6'd20, 6'd24, 6'd26, 6'd24, 6'd28, 6'd24, 6'd26, 6'd20},
    '{6'd12, 6'd12, 6'd16, 6'd16, 6'd16, 6'd20, 6'd22, 6'd20, 6'd24, 6'd20, 6'd22, 6'd16},
    '{6'd14, 6'd14, 6'd18, 6'd18, 6'd18, 6'd22, 6'd24, 6'd22, 6'd26, 6'd22, 6'd24, 6'd18},
    '{6'd8,  6'd8,  6'd12, 6'd12, 6'd12, 6'd16, 6'd18, 6'd16, 6'd20, 6'd16, 6'd18, 6'd12}
  };

  localparam logic [5:0] MOVE_LONG_TAB [NUM_CLASSES][NUM_CLASSES] = '{
    '{6'd4,  6'd4,  6'd12, 6'd12, 6'd12, 6'd16, 6'd18, 6'd16, 6'd20, 6'd16, 6'd18, 6'd12},
    '{6'd4,  6'd4,  6'd12, 6'd12, 6'd12, 6'd16, 6'd18, 6'd16, 6'd20, 6'd16, 6'd18, 6'd12},
    '{6'd12, 6'd12, 6'd20, 6'd20, 6'd20, 6'd24, 6'd26, 6'd24, 6'd28, 6'd24, 6'd26, 6'd20},
    '{6'd12, 6'd12, 6'd20, 6'd20, 6'd20, 6'd24, 6'd26, 6'd24, 6'd28, 6'd24, 6'd26, 6'd20},
    '{6'd14, 6'd14, 6'd22, 6'd22, 6'd22, 6'd26, 6'd28, 6'd26, 6'd30, 6'd26, 6'd28, 6'd22},
    '{6'd16, 6'd16, 6'd24, 6'd24, 6'd24, 6'd28, 6'd30, 6'd28, 6'd32, 6'd28, 6'd30, 6'd24},
    '{6'd18, 6'd18, 6'd26, 6'd26, 6'd26, 6'd30, 6'd32, 6'd30, 6'd34, 6'd30, 6'd32, 6'd26},
    '{6'd16, 6'd16, 6'd24, 6'd24, 6'd24, 6'd28, 6'd30, 6'd28, 6'd32, 6'd28, 6'd30, 6'd24},
    '{6'd20, 6'd20, 6'd28, 6'd28, 6'd28, 6'd32, 6'd34, 6'd32, 6'd36, 6'd32, 6'd34, 6'd28},
    '{6'd16, 6'd16, 6'd24, 6'd24, 6'd24, 6'd28, 6'd30, 6'd28, 6'd32, 6'd28, 6'd30, 6'd24},
    '{6'd18, 6'd18, 6'd26, 6'd26, 6'd26, 6'd30, 6'd32, 6'd30, 6'd34, 6'd30, 6'd32, 6'd26},
    '{6'd12, 6'd12, 6'd20, 6'd20, 6'd20, 6'd24, 6'd26, 6'd24, 6'd28, 6'd24, 6'd26, 6'd20}
  };

  function automatic logic [4:0] addr_cost(logic [2:0] mode, logic [2:0] rsel, logic lng);
    logic [4:0] cost;
    unique case (mode)
      3'd0, 3'd1: cost = 5'd0;
      3'd2, 3'd3: cost = lng ? 5'd8  : 5'd4;
      3'd4:       cost = lng ? 5'd10 : 5'd6;
      3'd5:       cost = lng ? 5'd12 : 5'd8;
      3'd6:       cost = lng ? 5'd14 : 5'd10;
      default: begin
        unique case (rsel)
          3'd0:    cost = lng ? 5'd12 : 5'd8;
          3'd1:    cost = lng ? 5'd16 : 5'd12;
          3'd2:    cost = lng ? 5'd12 : 5'd8;
          3'd3:    cost = lng ? 5'd14 : 5'd10;
          3'd4:    cost = lng ? 5'd8  : 5'd4;
          default: cost = 5'd8;  // unknown sub-mode, any size
        endcase
      end
    endcase
    return cost;
  endfunction

  // Unknown mode 7 sub-modes fold into class 0.
  function automatic logic [3:0] addr_class(logic [2:0] mode, logic [2:0] rsel);
    logic [3:0] cls;
    if (mode != 3'd7) begin
      cls = {1'b0, mode};
    end else if (rsel <= 3'd4) begin
      cls = 4'd7 + {1'b0, rsel};
    end else begin
      cls = 4'd0;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ict_queue.sv]
// Two-entry request queue between the front and the back.
// Depends on ict_pkg for req_t and QUEUE_DEPTH.
`default_nettype none

module ict_queue import ict_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  req_t      push_data_i,
  input  wire logic pop_i,
  output req_t      pop_data_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  req_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ict_front.sv]
// Front end: decodes the instruction fields into a classified request.
// Depends on ict_pkg for req_t, op_e and the address-mode functions.
`default_nettype none

module ict_front import ict_pkg::*; (
  input  wire logic [2:0] operation_i,
  input  wire logic [2:0] src_am_i,
  input  wire logic [2:0] src_reg_i,
  input  wire logic [2:0] dst_am_i,
  input  wire logic [2:0] dst_reg_i,
  input  wire logic [1:0] size_code_i,
  input  wire logic       direction_i,
  input  wire logic       memory_form_i,
  output req_t            req_o
);

  logic lng;
  logic src_reg_like;

  // Only bit 1 of the size code marks long.
  assign lng = size_code_i[1];
  assign src_reg_like = (src_am_i <= 3'd1) ||
                        ((src_am_i == 3'd7) && (src_reg_i == 3'd4));

  always_comb begin
    req_o.op        = operation_i;
    req_o.src_cls   = addr_class(src_am_i, src_reg_i);
    req_o.dst_cls   = addr_class(dst_am_i, dst_reg_i);
    req_o.lng       = lng;
    req_o.byte_sz   = (size_code_i == 2'd0);
    // Compare always takes the register-destination base.
    req_o.to_ea     = (op_e'(operation_i) == OP_ADD_SUB) && direction_i;
    req_o.wide_base = lng && src_reg_like;
    req_o.mem       = memory_form_i;
    req_o.ea_cost   = addr_cost(src_am_i, src_reg_i, lng);
  end

endmodule

`default_nettype wire

[rtl/core/ict_back.sv]
// Back end: looks up or adds up the cycle count and registers the result.
// Depends on ict_pkg for req_t, op_e and the move tables.
`default_nettype none

module ict_back import ict_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  req_t      req_i,
  output logic [5:0] cycles_o,
  output logic       done_o
);

  logic [4:0] base;
  logic [5:0] move_cyc;
  logic [5:0] cycles_d, cycles_q;
  logic       done_q;

  always_comb begin
    if (req_i.to_ea) begin
      base = req_i.lng ? 5'd12 : 5'd8;
    end else if (req_i.wide_base) begin
      base = 5'd8;
    end else begin
      base = req_i.lng ? 5'd6 : 5'd4;
    end
  end

  assign move_cyc = req_i.lng ? MOVE_LONG_TAB[req_i.dst_cls][req_i.src_cls]
                              : MOVE_BW_TAB[req_i.dst_cls][req_i.src_cls];

  always_comb begin
    unique case (op_e'(req_i.op))
      OP_EA_COST:             cycles_d = {1'b0, req_i.ea_cost};
      OP_MOVE:                cycles_d = move_cyc;
      OP_ADD_SUB, OP_CMP:     cycles_d = {1'b0, base} + {1'b0, req_i.ea_cost};
      OP_ADDX_SUBX: begin
        if (req_i.mem) begin
          cycles_d = req_i.byte_sz ? 6'd18 : 6'd30;
        end else begin
          cycles_d = req_i.byte_sz ? 6'd4 : 6'd8;
        end
      end
      default:                cycles_d = 6'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      cycles_q <= cycles_d;
    end
  end

  assign cycles_o = cycles_q;
  assign done_o   = done_q;

endmodule

`default_nettype wire

[rtl/core/instruction_cycle_timing.sv]
// Top level of the instruction cycle timing block: front decode, request
// queue and back lookup. Depends on ict_pkg, ict_front, ict_queue, ict_back.
//
//   channel   handshake          payload
//   request   start, busy        operation_i .. memory_form_i
//   result    done_o (strobe)    cycles_o
//
// One request per cycle while busy is low; the result passes through the queue
// and then the back-end result register before done_o strobes.
// The back end drains one entry every cycle, so the queue never fills and
// busy stays low in normal use. Reset clears the queue and the strobe.
// Results are never held: done_o is high for exactly one cycle per request.
`default_nettype none

module instruction_cycle_timing import ict_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] operation_i,
  input  wire logic [2:0] src_am_i,
  input  wire logic [2:0] src_reg_i,
  input  wire logic [2:0] dst_am_i,
  input  wire logic [2:0] dst_reg_i,
  input  wire logic [1:0] size_code_i,
  input  wire logic       direction_i,
  input  wire logic       memory_form_i,
  output logic [5:0]      cycles_o,
  output logic            done_o
);

  req_t front_req;
  req_t back_req;
  logic q_empty;
  logic q_full;

  ict_front u_front (
    .operation_i   (operation_i),
    .src_am_i      (src_am_i),
    .src_reg_i     (src_reg_i),
    .dst_am_i      (dst_am_i),
    .dst_reg_i     (dst_reg_i),
    .size_code_i   (size_code_i),
    .direction_i   (direction_i),
    .memory_form_i (memory_form_i),
    .req_o         (front_req)
  );

  ict_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start && !q_full),
    .push_data_i (front_req),
    .pop_i       (!q_empty),
    .pop_data_o  (back_req),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  ict_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (!q_empty),
    .req_i    (back_req),
    .cycles_o (cycles_o),
    .done_o   (done_o)
  );

  assign busy = q_full;

endmodule

`default_nettype wire

[rtl/core/ict_checker.sv]
// Port-level checker for instruction_cycle_timing, bound to the top level.
// Depends on instruction_cycle_timing_defines.svh for the assertion macros.
`default_nettype none
`include "instruction_cycle_timing_defines.svh"

module ict_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [5:0] cycles_o,
  input wire logic       done_o
);

  // Every accepted request is followed by its result strobe.
  `ICT_ASSERT_DLY(a_done_follows, start && !busy, 2, done_o, "result strobe missing")
  // No strobe without an earlier accepted request.
  `ICT_ASSERT_IMP(a_no_spurious, done_o, $past(start && !busy, 2), "result strobe invented")
  // All cycle counts are even.
  `ICT_ASSERT_IMP(a_even_count, done_o, !cycles_o[0], "odd cycle count")

endmodule

bind instruction_cycle_timing ict_checker u_ict_checker (.*);

`default_nettype wire
